>>> src/midi_note_stack_cv_engine_top_assert.svh
// Assertion macros for the checker of the note stack CV engine.
`ifndef MIDI_NOTE_STACK_CV_ENGINE_TOP_ASSERT_SVH
`define MIDI_NOTE_STACK_CV_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NMCV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NMCV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/nmcv_pkg.sv
// Package with constants, codes and types of the note stack CV engine.
package nmcv_pkg;

	localparam int MIDI_CHANNELS = 16;
	localparam int CH_W          = $clog2(MIDI_CHANNELS);
	localparam int STACK_DEPTH   = 128;
	localparam int STK_IDX_W     = $clog2(STACK_DEPTH);
	localparam int CNT_W         = STK_IDX_W + 1;
	localparam int NOTE_W        = 7;
	localparam int NOTE_DEPTH    = MIDI_CHANNELS * STACK_DEPTH;
	localparam int NOTE_ADDR_W   = $clog2(NOTE_DEPTH);
	localparam int CC_DEPTH      = MIDI_CHANNELS * 128;
	localparam int CC_ADDR_W     = $clog2(CC_DEPTH);
	localparam int QUEUE_DEPTH   = 4;
	localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_IDX_W     = 3;

	// MIDI status codes.
	localparam logic [7:0] ST_CLOCK    = 8'hf8;
	localparam logic [7:0] ST_START    = 8'hfa;
	localparam logic [7:0] ST_CONTINUE = 8'hfb;
	localparam logic [7:0] ST_STOP     = 8'hfc;
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_CTRL     = 8'hb0;
	localparam logic [7:0] KIND_MASK   = 8'hf0;
	localparam logic [7:0] CHAN_MASK   = 8'h0f;

	localparam logic [1:0] LEN_REALTIME = 2'd1;
	localparam logic [1:0] LEN_CHANNEL  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WATCH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CC    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIV   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE = 3'd4;

	typedef enum logic [2:0] {
		C_TICK, C_ON, C_OFF, C_CC, C_CLK, C_START, C_CONT, C_STOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CH_W-1:0]   ch;
		logic [NOTE_W-1:0] d1;
		logic [NOTE_W-1:0] d2;
	} cmd_t;

	typedef struct packed {
		logic [CH_W-1:0]   watch_channel;
		logic [NOTE_W-1:0] trig_note;
		logic [NOTE_W-1:0] cc_number;
		logic [6:0]        clock_division;
		logic [15:0]       pulse_frames;
	} cfg_t;

	typedef struct packed {
		logic [NOTE_W-1:0] pitch_note;
		logic              gate;
		logic              trig;
		logic [NOTE_W-1:0] velocity;
		logic [NOTE_W-1:0] cc_value;
		logic              clock_level;
	} res_t;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_TICK0, B_TICK1, B_SCAN, B_SHIFT,
		B_PUSH, B_RELRD, B_RELWT, B_CLKW, B_EMIT
	} back_state_t;

endpackage

>>> src/nmcv_ram.sv
// Generic single write port, single read port RAM with registered read.
module nmcv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> src/nmcv_rem.sv
// Bit-serial remainder unit: 32-bit tick count modulo a 7-bit divisor.
module nmcv_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [6:0]  divisor,
	output logic        done,
	output logic        rem_zero
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  bit_q;
	logic [31:0] dvd_q;
	logic [6:0]  div_q;
	logic [6:0]  rem_q;
	logic [7:0]  shifted;
	logic [7:0]  diff;

	// One restoring step per cycle, most significant bit first.
	assign shifted = {rem_q, dvd_q[31]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 5'd31;
			end else if (busy_q) begin
				bit_q <= bit_q - 5'd1;
				if (bit_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= (shifted >= {1'b0, div_q}) ? diff[6:0] : shifted[6:0];
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == 7'd0);
endmodule

>>> src/nmcv_front.sv
// Front end: accepts input items, classifies them and drops those with no effect.
module nmcv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                clearing,
	input  logic                mode,
	input  logic [1:0]          msg_len,
	input  logic [7:0]          status_byte,
	input  logic [6:0]          data_one,
	input  logic [6:0]          data_two,
	output logic                q_push,
	output nmcv_pkg::cmd_t      q_cmd,
	input  logic                q_full
);
	import nmcv_pkg::*;

	logic       v_s1;
	cmd_t       cmd_s1;
	cmd_t       cls;
	logic       keep;
	logic       accept;
	logic [7:0] kind;

	// Decode one item into a command for the back end.
	always_comb begin
		kind     = status_byte & KIND_MASK;
		cls.kind = C_TICK;
		cls.ch   = CH_W'(status_byte & CHAN_MASK);
		cls.d1   = data_one;
		cls.d2   = data_two;
		keep     = 1'b0;
		if (mode) begin
			keep = 1'b1;
		end else if (msg_len == LEN_REALTIME) begin
			keep = 1'b1;
			priority case (status_byte)
				ST_CLOCK:    cls.kind = C_CLK;
				ST_START:    cls.kind = C_START;
				ST_CONTINUE: cls.kind = C_CONT;
				ST_STOP:     cls.kind = C_STOP;
				default:     keep = 1'b0;
			endcase
		end else if (msg_len == LEN_CHANNEL) begin
			keep = 1'b1;
			priority case (kind)
				ST_NOTE_ON:  cls.kind = (data_two != 7'd0) ? C_ON : C_OFF;
				ST_NOTE_OFF: cls.kind = C_OFF;
				ST_CTRL:     cls.kind = C_CC;
				default:     keep = 1'b0;
			endcase
		end
	end

	assign full   = clearing || (v_s1 && q_full);
	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_cmd  = cmd_s1;

	// Single holding stage in front of the command queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= keep;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end
endmodule

>>> src/nmcv_cmdq.sv
// Short command queue between the front end and the back end.
module nmcv_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nmcv_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output nmcv_pkg::cmd_t rdata,
	output logic           empty
);
	import nmcv_pkg::*;

	cmd_t               ent_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wp_q;
	logic [Q_PTR_W-1:0] rp_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (cnt_q == (Q_PTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = ent_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= wdata;
		end
	end
endmodule

>>> src/nmcv_back.sv
// Back end: note stacks, controller store, clock transport and result register.
module nmcv_back (
	input  logic           clk,
	input  logic           arst_n,
	input  nmcv_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  nmcv_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           clearing,
	output logic           out_empty,
	input  logic           out_pop,
	output nmcv_pkg::res_t res
);
	import nmcv_pkg::*;

	back_state_t state_q, state_d;
	cmd_t        cmd_q, cmd_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [CNT_W-1:0]     ridx_q, ridx_d;
	logic [STK_IDX_W-1:0] widx_q, widx_d;
	logic                 pend_q, pend_d;
	logic [CC_ADDR_W-1:0] clr_q;
	res_t                 res_q, res_d;
	res_t                 out_q;
	logic                 out_v_q;
	logic                 out_load;

	logic [CNT_W-1:0]  held_q [MIDI_CHANNELS];
	logic [NOTE_W-1:0] top_q  [MIDI_CHANNELS];
	logic [NOTE_W-1:0] vel_q  [MIDI_CHANNELS];
	logic              held_we, top_we, vel_we;
	logic [NOTE_W-1:0] top_val;

	logic        running_q, running_d;
	logic [31:0] tick_q, tick_d;
	logic [15:0] pulse_q, pulse_d;

	logic                   st_we;
	logic [NOTE_ADDR_W-1:0] st_waddr, st_raddr;
	logic [NOTE_W-1:0]      st_wdata, st_rdata;
	logic                   cc_we;
	logic [CC_ADDR_W-1:0]   cc_waddr, cc_raddr;
	logic [NOTE_W-1:0]      cc_wdata, cc_rdata;

	logic              rem_start, rem_done, rem_zero;
	logic [6:0]        div_eff;
	logic              for_hold;
	logic [CH_W-1:0]   ch;
	logic [NOTE_W-1:0] target;
	logic              found;

	assign for_hold = (cmd_q.kind == C_TICK);
	assign ch       = for_hold ? cfg.watch_channel : cmd_q.ch;
	assign target   = for_hold ? cfg.trig_note : cmd_q.d1;
	assign found    = pend_q && (st_rdata == target);
	assign div_eff  = (cfg.clock_division == 7'd0) ? 7'd1 : cfg.clock_division;
	assign clearing = (state_q == B_CLEAR);

	// Sequencer for all commands.
	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		cnt_d     = cnt_q;
		ridx_d    = ridx_q;
		widx_d    = widx_q;
		pend_d    = pend_q;
		res_d     = res_q;
		running_d = running_q;
		tick_d    = tick_q;
		pulse_d   = pulse_q;
		held_we   = 1'b0;
		top_we    = 1'b0;
		vel_we    = 1'b0;
		top_val   = cmd_q.d1;
		st_we     = 1'b0;
		st_waddr  = {ch, widx_q};
		st_wdata  = st_rdata;
		st_raddr  = {ch, ridx_q[STK_IDX_W-1:0]};
		cc_we     = 1'b0;
		cc_waddr  = {q_head.ch, q_head.d1};
		cc_wdata  = q_head.d2;
		cc_raddr  = {cfg.watch_channel, cfg.cc_number};
		rem_start = 1'b0;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				cc_we    = 1'b1;
				cc_waddr = clr_q;
				cc_wdata = '0;
				if (clr_q == CC_ADDR_W'(CC_DEPTH - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					q_pop  = 1'b1;
					cmd_d  = q_head;
					ridx_d = '0;
					pend_d = 1'b0;
					unique case (q_head.kind)
						C_TICK: state_d = B_TICK0;
						C_ON, C_OFF: begin
							cnt_d   = held_q[q_head.ch];
							state_d = B_SCAN;
						end
						C_CC: cc_we = 1'b1;
						C_CLK: begin
							if (running_q) begin
								rem_start = 1'b1;
								state_d   = B_CLKW;
							end
						end
						C_START: begin
							tick_d    = '0;
							running_d = 1'b1;
						end
						C_CONT: running_d = 1'b1;
						C_STOP: begin
							running_d = 1'b0;
							pulse_d   = '0;
						end
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_TICK0: begin
				res_d.pitch_note  = top_q[ch];
				res_d.gate        = (held_q[ch] != '0);
				res_d.velocity    = vel_q[ch];
				res_d.clock_level = (pulse_q != 16'd0);
				if (pulse_q != 16'd0) begin
					pulse_d = pulse_q - 16'd1;
				end
				cnt_d   = held_q[ch];
				state_d = B_TICK1;
			end
			B_TICK1: begin
				res_d.cc_value = cc_rdata;
				state_d        = B_SCAN;
			end
			B_SCAN: begin
				// Walk the stack from the bottom, one read issued per cycle.
				if (found) begin
					if (for_hold) begin
						res_d.trig = 1'b1;
						state_d    = B_EMIT;
					end else begin
						ridx_d  = CNT_W'(widx_q) + CNT_W'(1);
						pend_d  = 1'b0;
						state_d = B_SHIFT;
					end
				end else if (ridx_q < cnt_q) begin
					pend_d = 1'b1;
					widx_d = ridx_q[STK_IDX_W-1:0];
					ridx_d = ridx_q + CNT_W'(1);
				end else if (for_hold) begin
					res_d.trig = 1'b0;
					state_d    = B_EMIT;
				end else begin
					state_d = (cmd_q.kind == C_ON) ? B_PUSH : B_RELRD;
				end
			end
			B_SHIFT: begin
				// Close the gap: each entry above the match moves down by one.
				if (pend_q) begin
					st_we  = 1'b1;
					widx_d = widx_q + STK_IDX_W'(1);
				end
				if (ridx_q < cnt_q) begin
					pend_d = 1'b1;
					ridx_d = ridx_q + CNT_W'(1);
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						cnt_d   = cnt_q - CNT_W'(1);
						state_d = (cmd_q.kind == C_ON) ? B_PUSH : B_RELRD;
					end
				end
			end
			B_PUSH: begin
				if (cnt_q < CNT_W'(STACK_DEPTH)) begin
					st_we    = 1'b1;
					st_waddr = {ch, cnt_q[STK_IDX_W-1:0]};
					st_wdata = cmd_q.d1;
					cnt_d    = cnt_q + CNT_W'(1);
				end
				held_we = 1'b1;
				top_we  = 1'b1;
				vel_we  = 1'b1;
				state_d = B_IDLE;
			end
			B_RELRD: begin
				held_we = 1'b1;
				if (cnt_q != '0) begin
					st_raddr = {ch, STK_IDX_W'(cnt_q - CNT_W'(1))};
					state_d  = B_RELWT;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_RELWT: begin
				top_we  = 1'b1;
				top_val = st_rdata;
				state_d = B_IDLE;
			end
			B_CLKW: begin
				if (rem_done) begin
					if (rem_zero) begin
						pulse_d = (cfg.pulse_frames == 16'd0) ? 16'd1 : cfg.pulse_frames;
					end
					tick_d  = tick_q + 32'd1;
					state_d = B_IDLE;
				end
			end
			B_EMIT: begin
				if (!out_v_q || out_pop) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			running_q <= 1'b1;
			tick_q    <= '0;
			pulse_q   <= '0;
			out_v_q   <= 1'b0;
			pend_q    <= 1'b0;
			for (int i = 0; i < MIDI_CHANNELS; i++) begin
				held_q[i] <= '0;
				top_q[i]  <= '0;
				vel_q[i]  <= '0;
			end
		end else begin
			state_q   <= state_d;
			running_q <= running_d;
			tick_q    <= tick_d;
			pulse_q   <= pulse_d;
			pend_q    <= pend_d;
			out_v_q   <= out_load || (out_v_q && !out_pop);
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + CC_ADDR_W'(1);
			end
			if (held_we) begin
				held_q[ch] <= cnt_d;
			end
			if (top_we) begin
				top_q[ch] <= top_val;
			end
			if (vel_we) begin
				vel_q[ch] <= cmd_q.d2;
			end
		end
	end

	// Working registers of the current command and the result register.
	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		cnt_q  <= cnt_d;
		ridx_q <= ridx_d;
		widx_q <= widx_d;
		res_q  <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_empty = !out_v_q;
	assign res       = out_q;

	nmcv_ram #(.WIDTH(NOTE_W), .DEPTH(NOTE_DEPTH)) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	nmcv_ram #(.WIDTH(NOTE_W), .DEPTH(CC_DEPTH)) u_cc (
		.clk   (clk),
		.we    (cc_we),
		.waddr (cc_waddr),
		.wdata (cc_wdata),
		.raddr (cc_raddr),
		.rdata (cc_rdata)
	);

	nmcv_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (tick_q),
		.divisor  (div_eff),
		.done     (rem_done),
		.rem_zero (rem_zero)
	);
endmodule

>>> src/midi_note_stack_cv_engine_top.sv
// MIDI to CV engine with last-note-priority stacks for 16 channels.
//
// Input items enter through push/full; an item with mode set is a frame tick,
// otherwise a MIDI message (length 1 real-time, length 3 channel message).
// Each frame tick yields one result on the output queue (empty/pop); messages
// yield none. The five registers are written through wr_en/wr_index/wr_data.
// The front end classifies items into commands and drops the ones that do
// nothing; a four-entry queue feeds the back end, which works one command at a
// time. In the back end a frame tick walks the stack for the trigger note;
// a note-on or note-off walks the stack and, if it finds the note, shifts
// the entries above it down through the note stack RAM; a MIDI clock takes
// a bit-serial remainder of the tick count by the division; other messages
// are handled in the idle state.
// After reset the controller store is cleared one entry per cycle, all 2048
// entries, with full held high. A stalled receiver keeps the result in the
// output register; the back end then waits with the next tick result while
// the queue and front end keep accepting items until they fill.
module midi_note_stack_cv_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          mode,
	input  logic [1:0]                    msg_len,
	input  logic [7:0]                    status_byte,
	input  logic [6:0]                    data_one,
	input  logic [6:0]                    data_two,
	output logic                          empty,
	input  logic                          pop,
	output logic [6:0]                    pitch_note,
	output logic                          gate,
	output logic                          trig,
	output logic [6:0]                    velocity,
	output logic [6:0]                    cc_value,
	output logic                          clock_level,
	input  logic                          wr_en,
	input  logic [nmcv_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [nmcv_pkg::CFG_DATA_W-1:0] wr_data
);
	import nmcv_pkg::*;

	cfg_t cfg_q;
	logic q_push, q_full, q_pop, q_empty, clearing;
	cmd_t q_wcmd, q_head;
	res_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watch_channel  <= '0;
			cfg_q.trig_note      <= 7'd60;
			cfg_q.cc_number      <= 7'd1;
			cfg_q.clock_division <= 7'd6;
			cfg_q.pulse_frames   <= 16'd480;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WATCH: cfg_q.watch_channel  <= wr_data[CH_W-1:0];
				REG_TRIG:  cfg_q.trig_note      <= wr_data[NOTE_W-1:0];
				REG_CC:    cfg_q.cc_number      <= wr_data[NOTE_W-1:0];
				REG_DIV:   cfg_q.clock_division <= wr_data[6:0];
				REG_PULSE: cfg_q.pulse_frames   <= wr_data[15:0];
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	nmcv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.clearing    (clearing),
		.mode        (mode),
		.msg_len     (msg_len),
		.status_byte (status_byte),
		.data_one    (data_one),
		.data_two    (data_two),
		.q_push      (q_push),
		.q_cmd       (q_wcmd),
		.q_full      (q_full)
	);

	nmcv_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wcmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_head),
		.empty  (q_empty)
	);

	nmcv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_empty (empty),
		.out_pop   (pop),
		.res       (res)
	);

	assign pitch_note  = res.pitch_note;
	assign gate        = res.gate;
	assign trig        = res.trig;
	assign velocity    = res.velocity;
	assign cc_value    = res.cc_value;
	assign clock_level = res.clock_level;
endmodule

>>> src/nmcv_checker.sv
// Port-level checker for the note stack CV engine, bound to the top level.
`include "midi_note_stack_cv_engine_top_assert.svh"

module nmcv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [6:0] pitch_note,
	input logic       gate,
	input logic       trig,
	input logic [6:0] velocity
);
	// A held trigger note implies a held note on the channel.
	`NMCV_ASSERT_NOW(a_trig_needs_gate, !empty && trig, gate, "trig without gate")
	// A held note came from a note-on, whose velocity is never zero.
	`NMCV_ASSERT_NOW(a_gate_velocity, !empty && gate, velocity != 7'd0, "gate with zero velocity")
	// A waiting item stays until it is taken.
	`NMCV_ASSERT_NEXT(a_hold_item, !empty && !pop, !empty, "waiting item lost")
	// A waiting item does not change while it waits.
	`NMCV_ASSERT_NEXT(a_hold_pitch, !empty && !pop, $stable(pitch_note), "waiting item changed")
endmodule

bind midi_note_stack_cv_engine_top nmcv_checker u_chk (.*);
